// File: hdl/cfd_pkg.sv
// Shared constants and controller/datapath interface types for the frame deframer.
`timescale 1ns / 1ps

package cfd_pkg;

   // Payload bytes per frame.
   localparam int PAYLOAD_LEN = 18;
   localparam int IDX_W = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

   // Field widths.
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 4;
   localparam int CHAN_W  = 3;
   localparam int BIDX_W  = 5;
   localparam int CSR_W   = 2;

   // Register indexes.
   localparam logic [CSR_W-1:0] CSR_START_MARKER  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_END_MARKER    = 2'd1;
   localparam logic [CSR_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Register reset values.
   localparam logic [BYTE_W-1:0]  START_MARKER_RST  = 8'h40;
   localparam logic [BYTE_W-1:0]  END_MARKER_RST    = 8'h23;
   localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 4'd8;
   localparam logic [COUNT_W-1:0] MAX_CHANNELS      = 4'd8;

   typedef struct packed {
      logic chan_load;   // latch channel, clear fill counter
      logic data_store;  // write payload byte, advance fill counter
      logic emit_clear;  // restart emit index
      logic emit_load;   // load next result into output register
   } cmd_type;

   typedef struct packed {
      logic start_hit;
      logic chan_ok;
      logic fill_last;
      logic end_hit;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

// File: hdl/cfd_ctrl.sv
// Frame deframer controller: hunt / channel / payload / end check / emit sequencing.
`timescale 1ns / 1ps

module cfd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cfd_pkg::status_type status,
   output cfd_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_HUNT = 5'b00001,
      ST_CHAN = 5'b00010,
      ST_DATA = 5'b00100,
      ST_END  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // input is held off only while a frame is being emitted
   assign req_stall = (state_ff == ST_EMIT);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_HUNT: begin
            if (accept && status.start_hit) begin
               state_in = ST_CHAN;
            end
         end
         ST_CHAN: begin
            if (accept) begin
               if (status.chan_ok) begin
                  cmd.chan_load = 1'b1;
                  state_in      = ST_DATA;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               cmd.data_store = 1'b1;
               if (status.fill_last) begin
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            if (accept) begin
               if (status.end_hit) begin
                  cmd.emit_clear = 1'b1;
                  state_in       = ST_EMIT;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/cfd_datapath.sv
// Frame deframer datapath: config registers, frame store, counters and result register.
`timescale 1ns / 1ps

module cfd_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [cfd_pkg::CSR_W-1:0]            csr_index,
   input  logic [cfd_pkg::BYTE_W-1:0]           csr_wdata,
   input  logic [cfd_pkg::BYTE_W-1:0]           req_rx_byte,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [cfd_pkg::CHAN_W-1:0]           rsp_channel,
   output logic [cfd_pkg::BIDX_W-1:0]           rsp_byte_index,
   output logic [cfd_pkg::BYTE_W-1:0]           rsp_payload_byte,
   output logic                                 rsp_last_byte,
   input  cfd_pkg::cmd_type                     cmd,
   output cfd_pkg::status_type                  status
);

   logic [cfd_pkg::BYTE_W-1:0]  start_marker_ff;
   logic [cfd_pkg::BYTE_W-1:0]  end_marker_ff;
   logic [cfd_pkg::COUNT_W-1:0] channel_count_ff;

   logic [cfd_pkg::IDX_W-1:0]   fill_ff;
   logic [cfd_pkg::IDX_W-1:0]   emit_ff;
   logic [cfd_pkg::CHAN_W-1:0]  frame_chan_ff;
   logic [cfd_pkg::BYTE_W-1:0]  store_ff [cfd_pkg::PAYLOAD_LEN];

   logic                        rsp_valid_ff;
   logic [cfd_pkg::CHAN_W-1:0]  rsp_channel_ff;
   logic [cfd_pkg::IDX_W-1:0]   rsp_idx_ff;
   logic [cfd_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic                        rsp_last_ff;

   logic [cfd_pkg::COUNT_W-1:0] limit;

   // channel counts above eight behave as eight
   assign limit = (channel_count_ff > cfd_pkg::MAX_CHANNELS) ? cfd_pkg::MAX_CHANNELS
                                                             : channel_count_ff;

   always_comb begin
      status.start_hit = (req_rx_byte == start_marker_ff);
      status.chan_ok   = (req_rx_byte != '0) &&
                         (req_rx_byte <= {{(cfd_pkg::BYTE_W-cfd_pkg::COUNT_W){1'b0}}, limit});
      status.fill_last = (fill_ff == cfd_pkg::LAST_IDX);
      status.end_hit   = (req_rx_byte == end_marker_ff);
      status.emit_last = (emit_ff == cfd_pkg::LAST_IDX);
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // configuration, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff  <= cfd_pkg::START_MARKER_RST;
         end_marker_ff    <= cfd_pkg::END_MARKER_RST;
         channel_count_ff <= cfd_pkg::CHANNEL_COUNT_RST;
      end else if (csr_write) begin
         if (csr_index == cfd_pkg::CSR_START_MARKER) begin
            start_marker_ff <= csr_wdata;
         end
         if (csr_index == cfd_pkg::CSR_END_MARKER) begin
            end_marker_ff <= csr_wdata;
         end
         if (csr_index == cfd_pkg::CSR_CHANNEL_COUNT) begin
            channel_count_ff <= csr_wdata[cfd_pkg::COUNT_W-1:0];
         end
      end
   end

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         emit_ff <= '0;
      end else begin
         if (cmd.chan_load) begin
            fill_ff <= '0;
         end else if (cmd.data_store) begin
            fill_ff <= status.fill_last ? '0 : fill_ff + 1'b1;
         end
         if (cmd.emit_clear) begin
            emit_ff <= '0;
         end else if (cmd.emit_load) begin
            emit_ff <= status.emit_last ? '0 : emit_ff + 1'b1;
         end
      end
   end

   // frame payload store and channel, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.chan_load) begin
         frame_chan_ff <= cfd_pkg::CHAN_W'(req_rx_byte - 8'd1);
      end
      if (cmd.data_store) begin
         store_ff[fill_ff] <= req_rx_byte;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_channel_ff <= frame_chan_ff;
         rsp_idx_ff     <= emit_ff;
         rsp_byte_ff    <= store_ff[emit_ff];
         rsp_last_ff    <= status.emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_byte_index   = cfd_pkg::BIDX_W'(rsp_idx_ff);
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_last_byte    = rsp_last_ff;

`ifndef ASSERT_OFF
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cfd_pkg::LAST_IDX)
      else $error("fill counter beyond frame length");

   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_idx_ff == cfd_pkg::LAST_IDX)))
      else $error("last flag not on final payload byte");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> status.out_free)
      else $error("result register overwritten while stalled");
`endif

endmodule

// File: hdl/channel_frame_deframer_core.sv
// Top level of the start/end marker byte frame deframer.
`timescale 1ns / 1ps
// Throughput: one received byte per cycle while hunting or receiving a frame.
// After a matching end marker the input stalls while the PAYLOAD_LEN (18)
// stored bytes are emitted, one result per cycle the output register is free.
// The end marker leads to the emit state, which loads the result register.
// Reset (synchronous, active high) restores register defaults and hunting;
// the frame store holds no reset value.

module channel_frame_deframer_core (
   input  logic                        clock,
   input  logic                        reset,
   // configuration write port
   input  logic                        csr_write,
   input  logic [cfd_pkg::CSR_W-1:0]   csr_index,
   input  logic [cfd_pkg::BYTE_W-1:0]  csr_wdata,
   // received byte items
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [cfd_pkg::BYTE_W-1:0]  req_rx_byte,
   // frame byte result items
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [cfd_pkg::CHAN_W-1:0]  rsp_channel,
   output logic [cfd_pkg::BIDX_W-1:0]  rsp_byte_index,
   output logic [cfd_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                        rsp_last_byte
);

   cfd_pkg::cmd_type    cmd;
   cfd_pkg::status_type status;

   // Controller walks hunt -> channel -> payload -> end check, and on a
   // matching end byte sequences the emit of the stored frame.
   cfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath holds the markers, channel limit, frame store, fill and emit
   // counters, and the result register that decouples the output side.
   cfd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_rx_byte      (req_rx_byte),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_channel      (rsp_channel),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last_byte    (rsp_last_byte),
      .cmd              (cmd),
      .status           (status)
   );

`ifndef ASSERT_OFF
   // emit only starts right after an accepted (end marker) item
   a_emit_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("emit started without an accepted item");

   // input is held off for the whole emit of a frame
   a_no_accept_mid_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && !status.emit_last) |-> req_stall)
      else $error("input accepted in the middle of a frame emit");

   // the emit leaves the stall state once the final byte is loaded
   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && status.emit_last) |=> !req_stall)
      else $error("input still stalled after frame emit");
`endif

endmodule
